// ===== rtl/core/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_pkg: shared types and constants for the hsv to rgb converter
// Holds the hue sextant codes, the arithmetic constants, the decode struct and div255.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	// fixed field widths
	localparam int HUE_W   = 9;
	localparam int CHAN_W  = 8;
	localparam int FRAC_W  = 6;
	localparam int SEXT_W  = 3;
	localparam int PROD_W  = 2 * CHAN_W;
	localparam int RAMP_W  = CHAN_W + FRAC_W;

	// arithmetic constants
	localparam logic [HUE_W-1:0]  SEXTANT_DEG = 9'd60;
	localparam logic [HUE_W-1:0]  HUE_LIMIT   = 9'd359;
	localparam logic [CHAN_W-1:0] FULL_SCALE  = 8'd255;

	// floor(x / 60) = (x * DIV60_RECIP) >> DIV60_SHIFT, exact for x below 2^14
	localparam int                DIV60_SHIFT = 20;
	localparam logic [14:0]       DIV60_RECIP = 15'd17477;
	localparam int                DIV60_PW    = RAMP_W + 15;

	// sextant codes
	localparam logic [SEXT_W-1:0] SEXT_0 = 3'd0;
	localparam logic [SEXT_W-1:0] SEXT_1 = 3'd1;
	localparam logic [SEXT_W-1:0] SEXT_2 = 3'd2;
	localparam logic [SEXT_W-1:0] SEXT_3 = 3'd3;
	localparam logic [SEXT_W-1:0] SEXT_4 = 3'd4;
	localparam logic [SEXT_W-1:0] SEXT_5 = 3'd5;

	// configuration register index
	localparam logic REG_BRIGHTNESS = 1'b0;

	// hue decode result
	typedef struct packed {
		logic              out_of_range;
		logic [SEXT_W-1:0] sextant;
		logic [FRAC_W-1:0] frac;
	} hue_dec_t;

	// floor(x / 255) for a 16-bit product, exact for x up to 65279 (any product of two 8-bit values)
	function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] sum;
		sum = {1'b0, x} + {9'd0, x[PROD_W-1:CHAN_W]} + 17'd1;
		return sum[PROD_W-1:CHAN_W];
	endfunction

endpackage

// ===== rtl/core/hsv_to_rgb_dimmed.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_dimmed: integer hsv to rgb conversion with brightness scaling
// Five-stage pipeline: decode and bottom level, ramp products, divide by 60,
// channel select and brightness product, divide by 255.
// ----------------------------------------------------------------------------
// pipeline: each transfer passes five register stages, s1 to s5, to reach the outputs
// throughput: one transfer per cycle while out_stall is low, every stage advances
// unless held; a stage holds only while the stage after it is full and stalled
// reset: arst_n clears all stage valid bits and sets brightness_q to 255
// ----------------------------------------------------------------------------
module hsv_to_rgb_dimmed (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [8:0]  hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  level,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        hue_out_of_range,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = hsvrgb_pkg::CHAN_W;
	localparam int FW = hsvrgb_pkg::FRAC_W;
	localparam int SW = hsvrgb_pkg::SEXT_W;
	localparam int PW = hsvrgb_pkg::PROD_W;
	localparam int RW = hsvrgb_pkg::RAMP_W;
	localparam int DW = hsvrgb_pkg::DIV60_PW;
	localparam int DS = hsvrgb_pkg::DIV60_SHIFT;

	// configuration register
	logic [CW-1:0] brightness_q;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == hsvrgb_pkg::REG_BRIGHTNESS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= hsvrgb_pkg::FULL_SCALE;
		end else if (cfg_wr) begin
			brightness_q <= pwdata[CW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == hsvrgb_pkg::REG_BRIGHTNESS) begin
			prdata[CW-1:0] = brightness_q;
		end
	end

	// stage handshake: a stage loads when it is empty or its successor moves
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;

	assign ready_s5 = !valid_s5 || !out_stall;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	// stage 1: hue decode and bottom level
	hsvrgb_pkg::hue_dec_t hue_dec;
	logic [PW-1:0]        bottom_prod;

	hsvrgb_hue_decode u_hue_decode (
		.hue (hue),
		.dec (hue_dec)
	);

	assign bottom_prod = PW'(hsvrgb_pkg::FULL_SCALE - saturation) * PW'(level);

	hsvrgb_pkg::hue_dec_t dec_s1;
	logic [CW-1:0]        bottom_s1, top_s1;

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			dec_s1    <= hue_dec;
			bottom_s1 <= bottom_prod[PW-1:CW];
			top_s1    <= level;
		end
	end

	// stage 2: ramp numerators
	logic [CW-1:0] span;
	logic [FW-1:0] fall_frac;

	assign span      = top_s1 - bottom_s1;
	assign fall_frac = hsvrgb_pkg::SEXTANT_DEG[FW-1:0] - dec_s1.frac;

	logic [RW-1:0] rise_num_s2, fall_num_s2;
	logic [CW-1:0] bottom_s2, top_s2;
	logic [SW-1:0] sext_s2;
	logic          oor_s2;

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			rise_num_s2 <= RW'(span) * RW'(dec_s1.frac);
			fall_num_s2 <= RW'(span) * RW'(fall_frac);
			bottom_s2   <= bottom_s1;
			top_s2      <= top_s1;
			sext_s2     <= dec_s1.sextant;
			oor_s2      <= dec_s1.out_of_range;
		end
	end

	// stage 3: divide by 60 through the reciprocal, add bottom
	logic [DW-1:0] rise_div, fall_div;

	assign rise_div = DW'(rise_num_s2) * DW'(hsvrgb_pkg::DIV60_RECIP);
	assign fall_div = DW'(fall_num_s2) * DW'(hsvrgb_pkg::DIV60_RECIP);

	logic [CW-1:0] rise_s3, fall_s3, bottom_s3, top_s3;
	logic [SW-1:0] sext_s3;
	logic          oor_s3;

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			rise_s3   <= rise_div[DS+CW-1:DS] + bottom_s2;
			fall_s3   <= fall_div[DS+CW-1:DS] + bottom_s2;
			bottom_s3 <= bottom_s2;
			top_s3    <= top_s2;
			sext_s3   <= sext_s2;
			oor_s3    <= oor_s2;
		end
	end

	// stage 4: pick channel levels per sextant, scale by brightness
	logic [CW-1:0] r_lvl, g_lvl, b_lvl;

	always_comb begin
		case (sext_s3)
			hsvrgb_pkg::SEXT_0: begin
				r_lvl = top_s3;    g_lvl = rise_s3;   b_lvl = bottom_s3;
			end
			hsvrgb_pkg::SEXT_1: begin
				r_lvl = fall_s3;   g_lvl = top_s3;    b_lvl = bottom_s3;
			end
			hsvrgb_pkg::SEXT_2: begin
				r_lvl = bottom_s3; g_lvl = top_s3;    b_lvl = rise_s3;
			end
			hsvrgb_pkg::SEXT_3: begin
				r_lvl = bottom_s3; g_lvl = fall_s3;   b_lvl = top_s3;
			end
			hsvrgb_pkg::SEXT_4: begin
				r_lvl = rise_s3;   g_lvl = bottom_s3; b_lvl = top_s3;
			end
			default: begin
				r_lvl = top_s3;    g_lvl = bottom_s3; b_lvl = fall_s3;
			end
		endcase
	end

	logic [PW-1:0] r_prod_s4, g_prod_s4, b_prod_s4;
	logic          oor_s4;

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			r_prod_s4 <= PW'(r_lvl) * PW'(brightness_q);
			g_prod_s4 <= PW'(g_lvl) * PW'(brightness_q);
			b_prod_s4 <= PW'(b_lvl) * PW'(brightness_q);
			oor_s4    <= oor_s3;
		end
	end

	// stage 5: divide by 255, blank colors for an invalid hue
	logic [CW-1:0] red_s5, green_s5, blue_s5;
	logic          oor_s5;

	always_ff @(posedge clk) begin
		if (ready_s5 && valid_s4) begin
			red_s5   <= oor_s4 ? '0 : hsvrgb_pkg::div255(r_prod_s4);
			green_s5 <= oor_s4 ? '0 : hsvrgb_pkg::div255(g_prod_s4);
			blue_s5  <= oor_s4 ? '0 : hsvrgb_pkg::div255(b_prod_s4);
			oor_s5   <= oor_s4;
		end
	end

	assign out_valid        = valid_s5;
	assign red              = red_s5;
	assign green            = green_s5;
	assign blue             = blue_s5;
	assign hue_out_of_range = oor_s5;

	// an invalid hue always leaves with black
	a_oor_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hue_out_of_range |-> red == '0 && green == '0 && blue == '0)
		else $error("out of range hue produced a color");

	// back pressure on the input only when every stage of the pipeline is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5)
		else $error("input stalled with a bubble in the pipeline");

	// a held first stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(dec_s1) && $stable(top_s1))
		else $error("first stage lost its item while held");

endmodule

// ===== rtl/core/hsvrgb_hue_decode.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_hue_decode: hue angle to sextant and remainder
// Splits a hue below 360 degrees into hue / 60 and hue % 60 by a compare
// chain and flags angles above 359.
// ----------------------------------------------------------------------------
module hsvrgb_hue_decode (
	input  logic [hsvrgb_pkg::HUE_W-1:0] hue,
	output hsvrgb_pkg::hue_dec_t         dec
);

	logic [hsvrgb_pkg::HUE_W-1:0]  base;
	logic [hsvrgb_pkg::HUE_W-1:0]  rem;
	logic [hsvrgb_pkg::SEXT_W-1:0] sext;

	// compare against the sextant boundaries
	always_comb begin
		sext = hsvrgb_pkg::SEXT_0;
		base = '0;
		if (hue >= 9'd60) begin
			sext = hsvrgb_pkg::SEXT_1;
			base = 9'd60;
		end
		if (hue >= 9'd120) begin
			sext = hsvrgb_pkg::SEXT_2;
			base = 9'd120;
		end
		if (hue >= 9'd180) begin
			sext = hsvrgb_pkg::SEXT_3;
			base = 9'd180;
		end
		if (hue >= 9'd240) begin
			sext = hsvrgb_pkg::SEXT_4;
			base = 9'd240;
		end
		if (hue >= 9'd300) begin
			sext = hsvrgb_pkg::SEXT_5;
			base = 9'd300;
		end
	end

	// remainder within the sextant, below 60 for valid angles
	assign rem = hue - base;

	assign dec.out_of_range = (hue > hsvrgb_pkg::HUE_LIMIT);
	assign dec.sextant      = sext;
	assign dec.frac         = rem[hsvrgb_pkg::FRAC_W-1:0];

endmodule
